FILE: design/basic_source_tokenizer_macros.svh
// Assertion macros shared by the tokenizer modules.
`ifndef BASIC_SOURCE_TOKENIZER_MACROS_SVH
`define BASIC_SOURCE_TOKENIZER_MACROS_SVH

// Condition must hold at every rising clock edge outside reset.
`define BST_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence must hold in the same cycle as the antecedent.
`define BST_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define BST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bst_pkg.sv
// Types, constants and character functions shared by the tokenizer modules.
package bst_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } bst_in_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [6:0]  keyword_code;
        logic [11:0] token_column;
        logic [11:0] token_length;
        logic        last_of_run;
    } bst_out_t;

    typedef struct packed {
        logic [1:0] count;
        bst_out_t   first;
        bst_out_t   second;
    } bst_res_t;

    localparam int BST_FIFO_DEPTH = 4;
    localparam int KW_BITS = 72;
    localparam int KW_COUNT = 128;

    localparam logic [4:0] K_NUMBER     = 5'd0;
    localparam logic [4:0] K_STRING     = 5'd1;
    localparam logic [4:0] K_IDENT      = 5'd2;
    localparam logic [4:0] K_KEYWORD    = 5'd3;
    localparam logic [4:0] K_PLUS       = 5'd4;
    localparam logic [4:0] K_MINUS      = 5'd5;
    localparam logic [4:0] K_STAR       = 5'd6;
    localparam logic [4:0] K_SLASH      = 5'd7;
    localparam logic [4:0] K_CARET      = 5'd8;
    localparam logic [4:0] K_LPAREN     = 5'd9;
    localparam logic [4:0] K_RPAREN     = 5'd10;
    localparam logic [4:0] K_COMMA      = 5'd11;
    localparam logic [4:0] K_SEMI       = 5'd12;
    localparam logic [4:0] K_COLON      = 5'd13;
    localparam logic [4:0] K_HASH       = 5'd14;
    localparam logic [4:0] K_DOLLAR     = 5'd15;
    localparam logic [4:0] K_PERCENT    = 5'd16;
    localparam logic [4:0] K_NEWLINE    = 5'd17;
    localparam logic [4:0] K_EQ         = 5'd18;
    localparam logic [4:0] K_LT         = 5'd19;
    localparam logic [4:0] K_GT         = 5'd20;
    localparam logic [4:0] K_LE         = 5'd21;
    localparam logic [4:0] K_GE         = 5'd22;
    localparam logic [4:0] K_NE         = 5'd23;

    localparam logic [6:0] KW_CLR   = 7'd34;
    localparam logic [6:0] KW_CLEAR = 7'd35;

    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_UP_E    = 8'h45;
    localparam logic [7:0] CH_LO_E    = 8'h65;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D) || (c == 8'h20);
    endfunction

    function automatic logic [7:0] to_upper(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
    endfunction

    function automatic logic [4:0] single_kind(logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            8'h5E:   k = K_CARET;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h2C:   k = K_COMMA;
            8'h3B:   k = K_SEMI;
            8'h3A:   k = K_COLON;
            8'h23:   k = K_HASH;
            8'h24:   k = K_DOLLAR;
            8'h25:   k = K_PERCENT;
            8'h3D:   k = K_EQ;
            default: k = K_NEWLINE;
        endcase
        return k;
    endfunction

    // Keyword text, right-aligned with zero fill on the left.
    function automatic logic [KW_BITS-1:0] kw_entry(logic [6:0] e);
        logic [KW_BITS-1:0] s;
        case (e)
            7'd0:    s = KW_BITS'("PRINT");
            7'd1:    s = KW_BITS'("?");
            7'd2:    s = KW_BITS'("INPUT");
            7'd3:    s = KW_BITS'("LET");
            7'd4:    s = KW_BITS'("IF");
            7'd5:    s = KW_BITS'("THEN");
            7'd6:    s = KW_BITS'("ELSE");
            7'd7:    s = KW_BITS'("GOTO");
            7'd8:    s = KW_BITS'("GOSUB");
            7'd9:    s = KW_BITS'("RETURN");
            7'd10:   s = KW_BITS'("FOR");
            7'd11:   s = KW_BITS'("TO");
            7'd12:   s = KW_BITS'("STEP");
            7'd13:   s = KW_BITS'("NEXT");
            7'd14:   s = KW_BITS'("DIM");
            7'd15:   s = KW_BITS'("DATA");
            7'd16:   s = KW_BITS'("READ");
            7'd17:   s = KW_BITS'("RESTORE");
            7'd18:   s = KW_BITS'("REM");
            7'd19:   s = KW_BITS'("END");
            7'd20:   s = KW_BITS'("NEW");
            7'd21:   s = KW_BITS'("RUN");
            7'd22:   s = KW_BITS'("LIST");
            7'd23:   s = KW_BITS'("LOAD");
            7'd24:   s = KW_BITS'("SAVE");
            7'd25:   s = KW_BITS'("CATALOG");
            7'd26:   s = KW_BITS'("CONT");
            7'd27:   s = KW_BITS'("DEL");
            7'd28:   s = KW_BITS'("DEF");
            7'd29:   s = KW_BITS'("FN");
            7'd30:   s = KW_BITS'("ONERR");
            7'd31:   s = KW_BITS'("RESUME");
            7'd32:   s = KW_BITS'("ON");
            7'd33:   s = KW_BITS'("AT");
            7'd34:   s = KW_BITS'("CLR");
            7'd35:   s = KW_BITS'("CLEAR");
            7'd36:   s = KW_BITS'("HOME");
            7'd37:   s = KW_BITS'("TEXT");
            7'd38:   s = KW_BITS'("GR");
            7'd39:   s = KW_BITS'("HIRES");
            7'd40:   s = KW_BITS'("COLOR=");
            7'd41:   s = KW_BITS'("HGR");
            7'd42:   s = KW_BITS'("HGR2");
            7'd43:   s = KW_BITS'("HCOLOR=");
            7'd44:   s = KW_BITS'("CALL");
            7'd45:   s = KW_BITS'("PEEK");
            7'd46:   s = KW_BITS'("POKE");
            7'd47:   s = KW_BITS'("GET");
            7'd48:   s = KW_BITS'("HTAB");
            7'd49:   s = KW_BITS'("VTAB");
            7'd50:   s = KW_BITS'("INVERSE");
            7'd51:   s = KW_BITS'("NORMAL");
            7'd52:   s = KW_BITS'("FLASH");
            7'd53:   s = KW_BITS'("STOP");
            7'd54:   s = KW_BITS'("PLOT");
            7'd55:   s = KW_BITS'("HLIN");
            7'd56:   s = KW_BITS'("VLIN");
            7'd57:   s = KW_BITS'("HPLOT");
            7'd58:   s = KW_BITS'("XDRAW");
            7'd59:   s = KW_BITS'("DRAW");
            7'd60:   s = KW_BITS'("MOVE");
            7'd61:   s = KW_BITS'("ROTATE");
            7'd62:   s = KW_BITS'("SCALE");
            7'd63:   s = KW_BITS'("SHLOAD");
            7'd64:   s = KW_BITS'("SIN");
            7'd65:   s = KW_BITS'("COS");
            7'd66:   s = KW_BITS'("TAN");
            7'd67:   s = KW_BITS'("ATN");
            7'd68:   s = KW_BITS'("EXP");
            7'd69:   s = KW_BITS'("LOG");
            7'd70:   s = KW_BITS'("SQR");
            7'd71:   s = KW_BITS'("ABS");
            7'd72:   s = KW_BITS'("INT");
            7'd73:   s = KW_BITS'("SGN");
            7'd74:   s = KW_BITS'("RND");
            7'd75:   s = KW_BITS'("LEN");
            7'd76:   s = KW_BITS'("VAL");
            7'd77:   s = KW_BITS'("ASC");
            7'd78:   s = KW_BITS'("CHR$");
            7'd79:   s = KW_BITS'("LEFT$");
            7'd80:   s = KW_BITS'("RIGHT$");
            7'd81:   s = KW_BITS'("MID$");
            7'd82:   s = KW_BITS'("STR$");
            7'd83:   s = KW_BITS'("TAB");
            7'd84:   s = KW_BITS'("SPC");
            7'd85:   s = KW_BITS'("POS");
            7'd86:   s = KW_BITS'("FRE");
            7'd87:   s = KW_BITS'("PDL");
            7'd88:   s = KW_BITS'("AND");
            7'd89:   s = KW_BITS'("OR");
            7'd90:   s = KW_BITS'("NOT");
            7'd91:   s = KW_BITS'("MOD");
            7'd92:   s = KW_BITS'("TRACE");
            7'd93:   s = KW_BITS'("NOTRACE");
            7'd94:   s = KW_BITS'("RANDOMIZE");
            7'd95:   s = KW_BITS'("SPEED");
            7'd96:   s = KW_BITS'("PR");
            7'd97:   s = KW_BITS'("IN");
            7'd98:   s = KW_BITS'("WHILE");
            7'd99:   s = KW_BITS'("WEND");
            7'd100:  s = KW_BITS'("POP");
            7'd101:  s = KW_BITS'("WAIT");
            7'd102:  s = KW_BITS'("HIMEM");
            7'd103:  s = KW_BITS'("LOMEM");
            7'd104:  s = KW_BITS'("SCRN");
            7'd105:  s = KW_BITS'("RECALL");
            7'd106:  s = KW_BITS'("STORE");
            7'd107:  s = KW_BITS'("TAPE");
            7'd108:  s = KW_BITS'("DELETE");
            7'd109:  s = KW_BITS'("RENAME");
            7'd110:  s = KW_BITS'("PREFIX");
            7'd111:  s = KW_BITS'("OPEN");
            7'd112:  s = KW_BITS'("CLOSE");
            7'd113:  s = KW_BITS'("APPEND");
            7'd114:  s = KW_BITS'("BLOAD");
            7'd115:  s = KW_BITS'("BRUN");
            7'd116:  s = KW_BITS'("BSAVE");
            7'd117:  s = KW_BITS'("CREATE");
            7'd118:  s = KW_BITS'("FLUSH");
            7'd119:  s = KW_BITS'("LOCK");
            7'd120:  s = KW_BITS'("UNLOCK");
            7'd121:  s = KW_BITS'("POSITION");
            7'd122:  s = KW_BITS'("CHAIN");
            7'd123:  s = KW_BITS'("EXEC");
            7'd124:  s = KW_BITS'("CAT");
            7'd125:  s = KW_BITS'("WRITE");
            7'd126:  s = KW_BITS'("-");
            7'd127:  s = KW_BITS'("USR");
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

FILE: design/basic_source_tokenizer.sv
// A character beat waits in the input register until the lexer step moves its tokens into the queue.
// Throughput: one character per cycle while the result queue has room for two beats;
// each character makes 0 to 2 token beats, drained one per cycle while tok_ready is high.
// The keyword table compare and the lexer decision are combinational between input register and queue.
// Reset (rst_n low, asynchronous) empties both stages and returns the lexer to column 1, no token.
module basic_source_tokenizer
    import bst_pkg::*;
#(
    parameter int WORD_CHARS = 9,
    parameter int MAX_COLUMN = 4095
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_ready,
    input  bst_in_t  src_beat,
    output logic     tok_valid,
    input  logic     tok_ready,
    output bst_out_t tok_beat
);

    logic       hold_valid_reg;
    bst_in_t    hold_beat_reg;
    logic       step;
    logic [2:0] free;
    bst_res_t   res;

    assign step      = hold_valid_reg && (free >= 3'd2);
    assign src_ready = !hold_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (src_valid && src_ready)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
        begin
            hold_beat_reg <= src_beat;
        end
    end

    bst_lexer #(
        .WORD_CHARS(WORD_CHARS),
        .MAX_COLUMN(MAX_COLUMN)
    ) u_lexer (
        .clk  (clk),
        .rst_n(rst_n),
        .step (step),
        .beat (hold_beat_reg),
        .res  (res)
    );

    bst_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (step),
        .res      (res),
        .tok_ready(tok_ready),
        .tok_valid(tok_valid),
        .tok_beat (tok_beat),
        .free     (free)
    );

endmodule

FILE: design/bst_lexer.sv
// Lexer state, word store, keyword match and per-character token decision.
`include "basic_source_tokenizer_macros.svh"

module bst_lexer
    import bst_pkg::*;
#(
    parameter int WORD_CHARS = 9,
    parameter int MAX_COLUMN = 4095
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  bst_in_t  beat,
    output bst_res_t res
);

    localparam int CW  = $clog2(MAX_COLUMN + 1);
    localparam int WCW = $clog2(WORD_CHARS + 1);
    localparam int WIW = $clog2(WORD_CHARS);
    localparam int KB  = 8 * WORD_CHARS;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_NUM     = 3'd1;
    localparam logic [2:0] MODE_STR     = 3'd2;
    localparam logic [2:0] MODE_WORD    = 3'd3;
    localparam logic [2:0] MODE_DOT     = 3'd4;
    localparam logic [2:0] MODE_LESS    = 3'd5;
    localparam logic [2:0] MODE_GREATER = 3'd6;

    typedef struct packed {
        logic [2:0]    mode;
        logic          sp;
        logic          se;
        logic          sa;
        logic [CW-1:0] col;
        logic [CW-1:0] scol;
        logic [CW-1:0] tlen;
        logic          pnl;
        logic          lht;
        logic [1:0]    n;
        bst_out_t      r0;
        bst_out_t      r1;
    } work_t;

    logic [2:0]     mode_reg;
    logic           sp_reg;
    logic           se_reg;
    logic           sa_reg;
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  scol_reg;
    logic [CW-1:0]  tlen_reg;
    logic           pnl_reg;
    logic           lht_reg;
    logic [WCW-1:0] cnt_reg;
    logic           long_reg;
    logic [7:0]     word_reg [WORD_CHARS];

    logic [WCW-1:0] cnt_next;
    logic           long_next;
    logic [WCW-1:0] cnt_base;
    logic           word_add;
    logic           word_wr;
    logic [7:0]     store_next [WORD_CHARS];
    logic [KB-1:0]  key;
    logic           kw_hit;
    logic [6:0]     kw_code;
    logic [4:0]     word_kind;
    logic [6:0]     word_code;
    work_t          w;

    function automatic work_t emit(work_t s, logic [4:0] k, logic [6:0] code);
        bst_out_t r;
        r.token_kind   = k;
        r.keyword_code = code;
        r.token_column = 12'(s.scol);
        r.token_length = 12'(s.tlen);
        r.last_of_run  = 1'b0;
        if (!((k == K_NEWLINE) && s.lht && s.pnl) && (s.n != 2'd2))
        begin
            if (s.n == 2'd0)
            begin
                s.r0 = r;
            end
            else
            begin
                s.r1 = r;
            end
            s.n   = s.n + 2'd1;
            s.pnl = (k == K_NEWLINE);
            s.lht = 1'b1;
        end
        return s;
    endfunction

    function automatic work_t adv(work_t s);
        if (s.col < CW'(MAX_COLUMN))
        begin
            s.col = s.col + CW'(1);
        end
        return s;
    endfunction

    function automatic work_t take(work_t s);
        s = adv(s);
        if (s.tlen < CW'(MAX_COLUMN))
        begin
            s.tlen = s.tlen + CW'(1);
        end
        return s;
    endfunction

    function automatic work_t finish(work_t s, logic [4:0] wk, logic [6:0] wc);
        case (s.mode)
            MODE_NUM:     s = emit(s, K_NUMBER, 7'd0);
            MODE_STR:     s = emit(s, K_STRING, 7'd0);
            MODE_WORD:    s = emit(s, wk, wc);
            MODE_DOT:     s = emit(s, K_NEWLINE, 7'd0);
            MODE_LESS:    s = emit(s, K_LT, 7'd0);
            MODE_GREATER: s = emit(s, K_GT, 7'd0);
            default:      s = s;
        endcase
        s.mode = MODE_IDLE;
        return s;
    endfunction

    function automatic work_t start_char(work_t s, logic [7:0] c);
        s.mode = MODE_IDLE;
        if (is_space(c))
        begin
            s = adv(s);
        end
        else
        begin
            s.scol = s.col;
            s.tlen = '0;
            s = take(s);
            if (is_digit(c))
            begin
                s.mode = MODE_NUM;
                s.sp   = 1'b0;
                s.se   = 1'b0;
                s.sa   = 1'b0;
            end
            else if (c == CH_DOT)
            begin
                s.mode = MODE_DOT;
            end
            else if (c == CH_QUOTE)
            begin
                s.mode = MODE_STR;
            end
            else if (is_alpha(c))
            begin
                s.mode = MODE_WORD;
            end
            else if (c == CH_LT)
            begin
                s.mode = MODE_LESS;
            end
            else if (c == CH_GT)
            begin
                s.mode = MODE_GREATER;
            end
            else
            begin
                s = emit(s, single_kind(c), 7'd0);
            end
        end
        return s;
    endfunction

    // The word store changes only through character additions, so its next contents follow
    // from the current contents, count, mode, exponent flag and character.
    always_comb
    begin
        logic is_e;
        logic new_word;
        logic cont_word;
        is_e = (beat.char_code == CH_UP_E) || (beat.char_code == CH_LO_E);
        new_word = is_alpha(beat.char_code) && (mode_reg != MODE_WORD)
            && (mode_reg != MODE_STR) && !((mode_reg == MODE_NUM) && is_e && !se_reg);
        cont_word = (mode_reg == MODE_WORD) && (is_alpha(beat.char_code)
            || is_digit(beat.char_code) || (beat.char_code == CH_DOLLAR)
            || (beat.char_code == CH_PERCENT));
        word_add  = new_word || cont_word;
        cnt_base  = new_word ? '0 : cnt_reg;
        long_next = new_word ? 1'b0 : long_reg;
        cnt_next  = cnt_base;
        word_wr   = 1'b0;
        if (word_add)
        begin
            if (cnt_base < WCW'(WORD_CHARS))
            begin
                word_wr  = 1'b1;
                cnt_next = cnt_base + WCW'(1);
            end
            else
            begin
                long_next = 1'b1;
            end
        end
        for (int i = 0; i < WORD_CHARS; i++)
        begin
            store_next[i] = word_reg[i];
        end
        if (word_wr)
        begin
            store_next[cnt_base[WIW-1:0]] = to_upper(beat.char_code);
        end
    end

    always_comb
    begin
        key = '0;
        for (int i = 0; i < WORD_CHARS; i++)
        begin
            if (WCW'(i) < cnt_next)
            begin
                key = {key[KB-9:0], store_next[i]};
            end
        end
        kw_hit  = 1'b0;
        kw_code = '0;
        for (int e = KW_COUNT - 1; e >= 0; e--)
        begin
            if (key == KB'(kw_entry(7'(e))))
            begin
                kw_hit  = 1'b1;
                kw_code = 7'(e);
            end
        end
        if (kw_code == KW_CLEAR)
        begin
            kw_code = KW_CLR;
        end
        if (kw_hit && !long_next)
        begin
            word_kind = K_KEYWORD;
            word_code = kw_code;
        end
        else
        begin
            word_kind = K_IDENT;
            word_code = '0;
        end
    end

    always_comb
    begin
        logic [7:0] c;
        c      = beat.char_code;
        w.mode = mode_reg;
        w.sp   = sp_reg;
        w.se   = se_reg;
        w.sa   = sa_reg;
        w.col  = col_reg;
        w.scol = scol_reg;
        w.tlen = tlen_reg;
        w.pnl  = pnl_reg;
        w.lht  = lht_reg;
        w.n    = 2'd0;
        w.r0   = '0;
        w.r1   = '0;
        case (mode_reg)
            MODE_NUM:
            begin
                if (is_digit(c))
                begin
                    w.sa = 1'b0;
                    w = take(w);
                end
                else if ((c == CH_DOT) && !w.sp && !w.se)
                begin
                    w.sp = 1'b1;
                    w.sa = 1'b0;
                    w = take(w);
                end
                else if (((c == CH_UP_E) || (c == CH_LO_E)) && !w.se)
                begin
                    w.se = 1'b1;
                    w.sa = 1'b1;
                    w = take(w);
                end
                else if (((c == CH_PLUS) || (c == CH_MINUS)) && w.sa)
                begin
                    w.sa = 1'b0;
                    w = take(w);
                end
                else
                begin
                    w = finish(w, word_kind, word_code);
                    w = start_char(w, c);
                end
            end
            MODE_STR:
            begin
                if (c == CH_QUOTE)
                begin
                    w = take(w);
                    w = emit(w, K_STRING, 7'd0);
                    w.mode = MODE_IDLE;
                end
                else if (c == CH_LF)
                begin
                    w = finish(w, word_kind, word_code);
                    w = start_char(w, c);
                end
                else
                begin
                    w = take(w);
                end
            end
            MODE_WORD:
            begin
                if (word_add)
                begin
                    w = take(w);
                end
                else
                begin
                    w = finish(w, word_kind, word_code);
                    w = start_char(w, c);
                end
            end
            MODE_DOT:
            begin
                if (is_digit(c))
                begin
                    w.mode = MODE_NUM;
                    w.sp   = 1'b1;
                    w.se   = 1'b0;
                    w.sa   = 1'b0;
                    w = take(w);
                end
                else
                begin
                    w = finish(w, word_kind, word_code);
                    w = start_char(w, c);
                end
            end
            MODE_LESS:
            begin
                if (c == CH_EQ)
                begin
                    w = take(w);
                    w = emit(w, K_LE, 7'd0);
                    w.mode = MODE_IDLE;
                end
                else if (c == CH_GT)
                begin
                    w = take(w);
                    w = emit(w, K_NE, 7'd0);
                    w.mode = MODE_IDLE;
                end
                else
                begin
                    w = finish(w, word_kind, word_code);
                    w = start_char(w, c);
                end
            end
            MODE_GREATER:
            begin
                if (c == CH_EQ)
                begin
                    w = take(w);
                    w = emit(w, K_GE, 7'd0);
                    w.mode = MODE_IDLE;
                end
                else
                begin
                    w = finish(w, word_kind, word_code);
                    w = start_char(w, c);
                end
            end
            default:
            begin
                w = start_char(w, c);
            end
        endcase
        if (beat.line_end)
        begin
            w = finish(w, word_kind, word_code);
            w.col  = CW'(1);
            w.scol = CW'(1);
            w.pnl  = 1'b0;
            w.lht  = 1'b0;
            w.sp   = 1'b0;
            w.se   = 1'b0;
            w.sa   = 1'b0;
        end
        if (w.n == 2'd1)
        begin
            w.r0.last_of_run = 1'b1;
        end
        if (w.n == 2'd2)
        begin
            w.r1.last_of_run = 1'b1;
        end
    end

    assign res.count  = w.n;
    assign res.first  = w.r0;
    assign res.second = w.r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            sp_reg   <= 1'b0;
            se_reg   <= 1'b0;
            sa_reg   <= 1'b0;
            col_reg  <= CW'(1);
            scol_reg <= CW'(1);
            tlen_reg <= '0;
            pnl_reg  <= 1'b0;
            lht_reg  <= 1'b0;
            cnt_reg  <= '0;
            long_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= w.mode;
            sp_reg   <= w.sp;
            se_reg   <= w.se;
            sa_reg   <= w.sa;
            col_reg  <= w.col;
            scol_reg <= w.scol;
            tlen_reg <= w.tlen;
            pnl_reg  <= w.pnl;
            lht_reg  <= w.lht;
            cnt_reg  <= cnt_next;
            long_reg <= long_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && word_wr)
        begin
            word_reg[cnt_base[WIW-1:0]] <= to_upper(beat.char_code);
        end
    end

    `BST_ASSERT_IMPLY(a_two_last, res.count == 2'd2, res.second.last_of_run && !res.first.last_of_run, "two-beat result marks the wrong beat as last")
    `BST_ASSERT_IMPLY(a_one_last, res.count == 2'd1, res.first.last_of_run, "single result beat not marked last")
    `BST_ASSERT_NEXT(a_line_reset, step && beat.line_end, (col_reg == CW'(1)) && !lht_reg && (mode_reg == MODE_IDLE), "line state not cleared after line end")

endmodule

FILE: design/bst_fifo.sv
// Result queue that takes up to two token beats per cycle and returns one while tok_ready is high.
`include "basic_source_tokenizer_macros.svh"

module bst_fifo
    import bst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  bst_res_t res,
    input  logic     tok_ready,
    output logic     tok_valid,
    output bst_out_t tok_beat,
    output logic [2:0] free
);

    logic [1:0] head_reg;
    logic [1:0] tail_reg;
    logic [2:0] cnt_reg;
    bst_out_t   entry_reg [BST_FIFO_DEPTH];
    logic [2:0] push_n;
    logic       pop;

    assign push_n    = push ? {1'b0, res.count} : 3'd0;
    assign tok_valid = (cnt_reg != 3'd0);
    assign pop       = tok_valid && tok_ready;
    assign tok_beat  = entry_reg[head_reg];
    assign free      = 3'(BST_FIFO_DEPTH) - cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            tail_reg <= tail_reg + push_n[1:0];
            if (pop)
            begin
                head_reg <= head_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + push_n - {2'b00, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 3'd0)
        begin
            entry_reg[tail_reg] <= res.first;
        end
        if (push_n == 3'd2)
        begin
            entry_reg[tail_reg + 2'd1] <= res.second;
        end
    end

    `BST_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= 3'(BST_FIFO_DEPTH), "queue count beyond depth")
    `BST_ASSERT_IMPLY(a_no_overflow, push, push_n <= free, "push into a full queue")
    `BST_ASSERT_NEXT(a_fill_shows, (cnt_reg == 3'd0) && (push_n != 3'd0), tok_valid, "queued beat not presented")

endmodule

FILE: sim/basic_source_tokenizer_tb.sv
// Self-checking testbench for the BASIC source tokenizer: directed table, then random lines around a directed section.
module basic_source_tokenizer_tb;
    import bst_pkg::*;

    localparam logic [6:0] KW_RANDOMIZE = 7'd94;
    localparam logic [6:0] KW_USR       = 7'd127;
    localparam int         HOLD_CYCLES  = 300;

    typedef enum logic [2:0] {
        LX_IDLE, LX_NUM, LX_STR, LX_WORD, LX_DOT, LX_LESS, LX_GREATER
    } lex_mode_e;

    typedef struct {
        bst_in_t  beat;
        bit       typed;
        bst_out_t want;
    } stim_t;

    logic     clk;
    logic     rst_n;
    logic     src_valid;
    logic     src_ready;
    bst_in_t  src_beat;
    logic     tok_valid;
    logic     tok_ready;
    bst_out_t tok_beat;

    basic_source_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_beat  (src_beat),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_beat  (tok_beat)
    );

    string kw_names [128] = '{
        "PRINT","?","INPUT","LET","IF","THEN","ELSE","GOTO","GOSUB","RETURN",
        "FOR","TO","STEP","NEXT","DIM","DATA","READ","RESTORE","REM","END",
        "NEW","RUN","LIST","LOAD","SAVE","CATALOG","CONT","DEL","DEF","FN",
        "ONERR","RESUME","ON","AT","CLR","CLEAR","HOME","TEXT","GR","HIRES",
        "COLOR=","HGR","HGR2","HCOLOR=","CALL","PEEK","POKE","GET","HTAB","VTAB",
        "INVERSE","NORMAL","FLASH","STOP","PLOT","HLIN","VLIN","HPLOT","XDRAW","DRAW",
        "MOVE","ROTATE","SCALE","SHLOAD","SIN","COS","TAN","ATN","EXP","LOG",
        "SQR","ABS","INT","SGN","RND","LEN","VAL","ASC","CHR$","LEFT$",
        "RIGHT$","MID$","STR$","TAB","SPC","POS","FRE","PDL","AND","OR",
        "NOT","MOD","TRACE","NOTRACE","RANDOMIZE","SPEED","PR","IN","WHILE","WEND",
        "POP","WAIT","HIMEM","LOMEM","SCRN","RECALL","STORE","TAPE","DELETE","RENAME",
        "PREFIX","OPEN","CLOSE","APPEND","BLOAD","BRUN","BSAVE","CREATE","FLUSH","LOCK",
        "UNLOCK","POSITION","CHAIN","EXEC","CAT","WRITE","-","USR"
    };

    stim_t    stim [$];
    bst_out_t pending_tokens [$];
    logic [7:0] line_q [$];
    int       acc_idx;
    int       calm_from;
    int       hold_at;
    int       pause_at;
    bit       hold_req;
    bit       failed;

    lex_mode_e  lx_mode;
    bit         pt_seen, exp_seen, sign_ok;
    logic [7:0] wbuf [9];
    int         wcnt;
    bit         wlong;
    int         col, scol, tlen;
    bit         prev_nl, line_tok;
    bst_out_t   res [2];
    int         nres;

    function automatic bit digit_char(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter_char(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit blank_char(logic [7:0] c);
        return c == 8'd9 || c == 8'd11 || c == 8'd12 || c == 8'd13 || c == 8'd32;
    endfunction

    function automatic logic [4:0] op_kind(logic [7:0] c);
        case (c)
            "+":     return K_PLUS;
            "-":     return K_MINUS;
            "*":     return K_STAR;
            "/":     return K_SLASH;
            "^":     return K_CARET;
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            ",":     return K_COMMA;
            ";":     return K_SEMI;
            ":":     return K_COLON;
            "#":     return K_HASH;
            "$":     return K_DOLLAR;
            "%":     return K_PERCENT;
            "=":     return K_EQ;
            default: return K_NEWLINE;
        endcase
    endfunction

    function void put_token(logic [4:0] kind, logic [6:0] code);
        if (kind == K_NEWLINE && line_tok && prev_nl)
            return;
        if (nres >= 2)
            return;
        res[nres] = '{kind, code, scol[11:0], tlen[11:0], 1'b0};
        nres++;
        prev_nl = (kind == K_NEWLINE);
        line_tok = 1;
    endfunction

    function void bump_col();
        if (col < 4095)
            col++;
    endfunction

    function void consume();
        bump_col();
        if (tlen < 4095)
            tlen++;
    endfunction

    function void add_letter(logic [7:0] c);
        if (wcnt < 9)
        begin
            wbuf[wcnt] = (c >= "a" && c <= "z") ? c - 8'd32 : c;
            wcnt++;
        end
        else
            wlong = 1;
        consume();
    endfunction

    function void close_word();
        string s;
        bit    ok;
        if (!wlong)
        begin
            for (int e = 0; e < 128; e++)
            begin
                s = kw_names[e];
                ok = (s.len() == wcnt);
                for (int i = 0; ok && i < wcnt; i++)
                    if (s[i] != wbuf[i])
                        ok = 0;
                if (ok)
                begin
                    put_token(K_KEYWORD, (e == KW_CLEAR) ? KW_CLR : 7'(e));
                    return;
                end
            end
        end
        put_token(K_IDENT, 7'd0);
    endfunction

    function void lex_flush();
        case (lx_mode)
            LX_NUM:     put_token(K_NUMBER, 7'd0);
            LX_STR:     put_token(K_STRING, 7'd0);
            LX_WORD:    close_word();
            LX_DOT:     put_token(K_NEWLINE, 7'd0);
            LX_LESS:    put_token(K_LT, 7'd0);
            LX_GREATER: put_token(K_GT, 7'd0);
            default:    ;
        endcase
        lx_mode = LX_IDLE;
    endfunction

    function void lex_start(logic [7:0] c);
        lx_mode = LX_IDLE;
        if (blank_char(c))
        begin
            bump_col();
            return;
        end
        scol = col;
        tlen = 0;
        if (letter_char(c))
        begin
            lx_mode = LX_WORD;
            wcnt = 0;
            wlong = 0;
            add_letter(c);
            return;
        end
        consume();
        if (digit_char(c))
        begin
            lx_mode = LX_NUM;
            pt_seen = 0;
            exp_seen = 0;
            sign_ok = 0;
        end
        else if (c == CH_DOT)
            lx_mode = LX_DOT;
        else if (c == CH_QUOTE)
            lx_mode = LX_STR;
        else if (c == CH_LT)
            lx_mode = LX_LESS;
        else if (c == CH_GT)
            lx_mode = LX_GREATER;
        else
            put_token(op_kind(c), 7'd0);
    endfunction

    function void lex_restart(logic [7:0] c);
        lex_flush();
        lex_start(c);
    endfunction

    function void lex_feed(logic [7:0] c);
        case (lx_mode)
            LX_NUM:
                if (digit_char(c))
                begin
                    sign_ok = 0;
                    consume();
                end
                else if (c == CH_DOT && !pt_seen && !exp_seen)
                begin
                    pt_seen = 1;
                    sign_ok = 0;
                    consume();
                end
                else if ((c == CH_UP_E || c == CH_LO_E) && !exp_seen)
                begin
                    exp_seen = 1;
                    sign_ok = 1;
                    consume();
                end
                else if ((c == CH_PLUS || c == CH_MINUS) && sign_ok)
                begin
                    sign_ok = 0;
                    consume();
                end
                else
                    lex_restart(c);
            LX_STR:
                if (c == CH_QUOTE)
                begin
                    consume();
                    put_token(K_STRING, 7'd0);
                    lx_mode = LX_IDLE;
                end
                else if (c == CH_LF)
                    lex_restart(c);
                else
                    consume();
            LX_WORD:
                if (letter_char(c) || digit_char(c) || c == CH_DOLLAR || c == CH_PERCENT)
                    add_letter(c);
                else
                    lex_restart(c);
            LX_DOT:
                if (digit_char(c))
                begin
                    lx_mode = LX_NUM;
                    pt_seen = 1;
                    exp_seen = 0;
                    sign_ok = 0;
                    consume();
                end
                else
                    lex_restart(c);
            LX_LESS:
                if (c == CH_EQ || c == CH_GT)
                begin
                    consume();
                    put_token((c == CH_EQ) ? K_LE : K_NE, 7'd0);
                    lx_mode = LX_IDLE;
                end
                else
                    lex_restart(c);
            LX_GREATER:
                if (c == CH_EQ)
                begin
                    consume();
                    put_token(K_GE, 7'd0);
                    lx_mode = LX_IDLE;
                end
                else
                    lex_restart(c);
            default:
                lex_start(c);
        endcase
    endfunction

    function void lexer_clear();
        lx_mode = LX_IDLE;
        pt_seen = 0;
        exp_seen = 0;
        sign_ok = 0;
        wcnt = 0;
        wlong = 0;
        col = 1;
        scol = 1;
        tlen = 0;
        prev_nl = 0;
        line_tok = 0;
    endfunction

    function void predict_tokens(bst_in_t b);
        nres = 0;
        lex_feed(b.char_code);
        if (b.line_end)
        begin
            lex_flush();
            col = 1;
            scol = 1;
            prev_nl = 0;
            line_tok = 0;
            pt_seen = 0;
            exp_seen = 0;
            sign_ok = 0;
        end
        if (nres > 0)
            res[nres - 1].last_of_run = 1'b1;
    endfunction

    function automatic logic [7:0] rand_letter();
        return (($urandom_range(0, 1) != 0) ? "A" : "a") + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return "0" + 8'($urandom_range(0, 9));
    endfunction

    function void add_char(logic [7:0] c);
        line_q.insert(line_q.size(), c);
    endfunction

    function void push_row(logic [7:0] c, bit le, bit typed, bst_out_t want);
        stim_t row;
        row = '{'{c, le}, typed, want};
        stim.insert(stim.size(), row);
    endfunction

    function void push_line();
        for (int i = 0; i < line_q.size(); i++)
            push_row(line_q[i], i == line_q.size() - 1, 0, '0);
        line_q.delete();
    endfunction

    function void push_text(string s, bit le_at_end);
        for (int i = 0; i < s.len(); i++)
            push_row(s[i], le_at_end && i == s.len() - 1, 0, '0);
    endfunction

    function void push_checked(string s, logic [4:0] kind, logic [6:0] code);
        push_text(s.substr(0, s.len() - 2), 0);
        push_row(s[s.len() - 1], 1, 1,
                 '{kind, code, 12'd1, 12'(s.len()), 1'b1});
    endfunction

    function void gen_token();
        string      s;
        string      ops;
        logic [7:0] ch;
        int         n;
        ops = "+-*/^(),;:#$%=";
        case ($urandom_range(0, 11))
            0:
            begin
                if ($urandom_range(0, 3) == 0)
                    add_char(CH_DOT);
                n = $urandom_range(1, 3);
                repeat (n) add_char(rand_digit());
                if ($urandom_range(0, 1) != 0)
                begin
                    add_char(CH_DOT);
                    repeat ($urandom_range(0, 2)) add_char(rand_digit());
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    add_char(($urandom_range(0, 1) != 0) ? CH_UP_E : CH_LO_E);
                    if ($urandom_range(0, 1) != 0)
                        add_char(($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS);
                    repeat ($urandom_range(0, 2)) add_char(rand_digit());
                end
            end
            1:
            begin
                s = kw_names[$urandom_range(0, 127)];
                for (int i = 0; i < s.len(); i++)
                begin
                    ch = s[i];
                    if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) != 0)
                        ch = ch + 8'd32;
                    add_char(ch);
                end
            end
            2:
            begin
                add_char(rand_letter());
                repeat ($urandom_range(0, 4))
                    case ($urandom_range(0, 5))
                        0:       add_char(CH_DOLLAR);
                        1:       add_char(CH_PERCENT);
                        2:       add_char(rand_digit());
                        default: add_char(rand_letter());
                    endcase
            end
            3:  repeat ($urandom_range(10, 14)) add_char(rand_letter());
            4:
            begin
                add_char(CH_QUOTE);
                repeat ($urandom_range(0, 6))
                begin
                    ch = 8'($urandom_range(32, 126));
                    add_char((ch == CH_QUOTE) ? "a" : ch);
                end
                if ($urandom_range(0, 3) != 0)
                    add_char(CH_QUOTE);
            end
            5:  add_char(ops[$urandom_range(0, ops.len() - 1)]);
            6:
            begin
                add_char(($urandom_range(0, 1) != 0) ? CH_LT : CH_GT);
                case ($urandom_range(0, 2))
                    0:       add_char(CH_EQ);
                    1:       add_char(CH_GT);
                    default: ;
                endcase
            end
            7:
                case ($urandom_range(0, 4))
                    0:       add_char(8'd9);
                    1:       add_char(8'd11);
                    2:       add_char(8'd12);
                    3:       add_char(8'd13);
                    default: add_char(8'd32);
                endcase
            8:  add_char(8'($urandom_range(0, 255)));
            9:  add_char(CH_LF);
            10:
            begin
                add_char(CH_DOT);
                add_char(CH_PLUS);
            end
            default: add_char(rand_letter());
        endcase
        if ($urandom_range(0, 1) != 0)
            add_char(8'd32);
    endfunction

    function void gen_random(int count);
        int start;
        start = stim.size();
        while (stim.size() - start < count)
        begin
            repeat ($urandom_range(1, 6)) gen_token();
            push_line();
        end
    endfunction

    function void build_stimulus();
        push_row("+", 1, 1, '{K_PLUS, 7'd0, 12'd1, 12'd1, 1'b1});
        push_row("?", 1, 1, '{K_NEWLINE, 7'd0, 12'd1, 12'd1, 1'b1});
        push_row(8'hFF, 1, 1, '{K_NEWLINE, 7'd0, 12'd1, 12'd1, 1'b1});
        push_row(8'h00, 1, 1, '{K_NEWLINE, 7'd0, 12'd1, 12'd1, 1'b1});
        push_row(CH_DOT, 1, 1, '{K_NEWLINE, 7'd0, 12'd1, 12'd1, 1'b1});
        push_row(CH_LT, 1, 1, '{K_LT, 7'd0, 12'd1, 12'd1, 1'b1});
        push_row(CH_GT, 1, 1, '{K_GT, 7'd0, 12'd1, 12'd1, 1'b1});
        push_row(CH_DOLLAR, 1, 1, '{K_DOLLAR, 7'd0, 12'd1, 12'd1, 1'b1});
        push_row(CH_PERCENT, 1, 1, '{K_PERCENT, 7'd0, 12'd1, 12'd1, 1'b1});
        push_checked("ClEaR", K_KEYWORD, KW_CLR);
        push_checked("usr", K_KEYWORD, KW_USR);
        push_checked("RANDOMIZE", K_KEYWORD, KW_RANDOMIZE);
        push_checked("<=", K_LE, 7'd0);
        hold_at = stim.size() + 60;
        gen_random(325);
        pause_at = stim.size();
        repeat (20) push_row(8'd32, 0, 0, '0);
        push_row("A", 1, 0, '0);
        push_row(CH_QUOTE, 0, 0, '0);
        repeat (20) push_row("x", 0, 0, '0);
        push_row("x", 1, 0, '0);
        gen_random(325);
        calm_from = stim.size() - 100;
    endfunction

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && src_valid && src_ready)
        begin
            predict_tokens(src_beat);
            if (stim[acc_idx].typed)
                pending_tokens.insert(pending_tokens.size(), stim[acc_idx].want);
            else
                for (int i = 0; i < nres; i++)
                    pending_tokens.insert(pending_tokens.size(), res[i]);
            acc_idx++;
        end
    end

    always @(posedge clk)
    begin
        bst_out_t w;
        if (rst_n && tok_valid && tok_ready)
        begin
            if (pending_tokens.size() == 0)
            begin
                $error("token beat with no token expected");
                failed = 1;
            end
            else
            begin
                w = pending_tokens.pop_front();
                if (tok_beat.token_kind !== w.token_kind)
                begin
                    $error("token_kind expected %0d got %0d", w.token_kind, tok_beat.token_kind);
                    failed = 1;
                end
                if (tok_beat.keyword_code !== w.keyword_code)
                begin
                    $error("keyword_code expected %0d got %0d", w.keyword_code,
                           tok_beat.keyword_code);
                    failed = 1;
                end
                if (tok_beat.token_column !== w.token_column)
                begin
                    $error("token_column expected %0d got %0d", w.token_column,
                           tok_beat.token_column);
                    failed = 1;
                end
                if (tok_beat.token_length !== w.token_length)
                begin
                    $error("token_length expected %0d got %0d", w.token_length,
                           tok_beat.token_length);
                    failed = 1;
                end
                if (tok_beat.last_of_run !== w.last_of_run)
                begin
                    $error("last_of_run expected %0d got %0d", w.last_of_run,
                           tok_beat.last_of_run);
                    failed = 1;
                end
            end
        end
    end

    initial
    begin
        tok_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                tok_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            else if (acc_idx >= calm_from || $urandom_range(0, 3) != 0)
            begin
                tok_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                tok_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        src_valid = 1'b0;
        src_beat = '0;
        failed = 0;
        hold_req = 0;
        acc_idx = 0;
        lexer_clear();
        build_stimulus();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int idx = 0; idx < stim.size(); idx++)
        begin
            if (idx == hold_at)
                hold_req = 1;
            src_valid <= 1'b1;
            src_beat <= stim[idx].beat;
            @(posedge clk);
            while (!src_ready)
                @(posedge clk);
            if (idx + 1 == pause_at)
            begin
                src_valid <= 1'b0;
                while (pending_tokens.size() != 0)
                    @(posedge clk);
            end
            else if (idx + 1 < calm_from && $urandom_range(0, 4) == 0)
            begin
                src_valid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
        src_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_tokens.size() != 0)
        begin
            $error("%0d expected tokens never arrived", pending_tokens.size());
            failed = 1;
        end
        if (!failed)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
